// File: design/token_type_classifier_unit_assert.svh
// Assertion macros used by the token classifier RTL.
`ifndef TOKEN_TYPE_CLASSIFIER_UNIT_ASSERT_SVH
`define TOKEN_TYPE_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define TTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("token classifier check failed");
// Next-cycle implication, checked out of reset.
`define TTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token classifier check failed");
`else
`define TTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/ttc_pkg.sv
// Types and constants of the token classifier.
package ttc_pkg;

  localparam int CH_W  = 8;
  localparam int CLS_W = 3;
  localparam int CNT_W = 3;

  localparam logic [CNT_W-1:0] COUNT_SAT = 3'd6;

  localparam logic [CH_W-1:0] QUOTE_CH = 8'h22;
  localparam logic [CH_W-1:0] DOT_CH   = 8'h2E;
  localparam logic [CH_W-1:0] UNDER_CH = 8'h5F;
  localparam logic [CH_W-1:0] PLUS_CH  = 8'h2B;
  localparam logic [CH_W-1:0] MINUS_CH = 8'h2D;

  typedef enum logic [CLS_W-1:0] {
    CLS_INVALID = 3'd0,
    CLS_STRING  = 3'd1,
    CLS_BOOLEAN = 3'd2,
    CLS_INTEGER = 3'd3,
    CLS_FLOAT   = 3'd4,
    CLS_NAME    = 3'd5
  } tok_class_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             opened_quote;
    logic             latest_quote;
    logic             matches_true;
    logic             matches_false;
    logic             number_ok;
    logic             dot_seen;
    logic             name_ok;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    cnt:           '0,
    opened_quote:  1'b0,
    latest_quote:  1'b0,
    matches_true:  1'b1,
    matches_false: 1'b1,
    number_ok:     1'b1,
    dot_seen:      1'b0,
    name_ok:       1'b1
  };

  // Result handed from the scanner to the output register.
  typedef struct packed {
    tok_class_t cls;
    logic       bool_value;
  } scan_result_t;

endpackage

// File: design/ttc_if.sv
// Valid/ready channel interfaces for characters in and classes out.
interface ttc_in_if;
  logic                      valid;
  logic                      ready;
  logic [ttc_pkg::CH_W-1:0]  ch;
  logic                      last_char;
  logic                      empty_token;

  modport source (output valid, output ch, output last_char, output empty_token,
                  input ready);
  modport sink (input valid, input ch, input last_char, input empty_token,
                output ready);
endinterface

interface ttc_out_if;
  logic                      valid;
  logic                      ready;
  logic [ttc_pkg::CLS_W-1:0] token_class;
  logic                      bool_value;

  modport source (output valid, output token_class, output bool_value, input ready);
  modport sink (input valid, input token_class, input bool_value, output ready);
endinterface

// File: design/token_type_classifier_unit.sv
// The input register feeds the flag update and the classifier; for the last character of a token
// the result lands in the output register and stays valid there until it is taken.
// Throughput: one character per cycle, except while a last character waits behind a result.
// The input stays ready while a result waits, unless a last character is held behind it.
// Reset (synchronous, rst_n low) empties both registers and returns the token flags to their start values.
`include "token_type_classifier_unit_assert.svh"

module token_type_classifier_unit (
  input  logic      clk,
  input  logic      rst_n,
  ttc_in_if.sink    in_tok,
  ttc_out_if.source out_res
);

  logic                     s1_valid_r, s1_valid_nxt;
  logic [ttc_pkg::CH_W-1:0] s1_ch_r;
  logic                     s1_last_r, s1_empty_r;
  logic                     s1_go, in_take;
  logic                     out_valid_r, out_valid_nxt;
  ttc_pkg::scan_result_t    res, out_res_r;

  // A character that ends no token needs no output slot.
  assign s1_go   = s1_valid_r && (!s1_last_r || !out_valid_r || out_res.ready);
  assign in_take = in_tok.valid && in_tok.ready;
  assign in_tok.ready = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  ttc_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (s1_go),
    .ch          (s1_ch_r),
    .last_char   (s1_last_r),
    .empty_token (s1_empty_r),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_take) begin
      s1_ch_r    <= in_tok.ch;
      s1_last_r  <= in_tok.last_char;
      s1_empty_r <= in_tok.empty_token;
    end
    if (s1_go && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.token_class = out_res_r.cls;
  assign out_res.bool_value  = out_res_r.bool_value;

  `TTC_ASSERT_IMPLY(a_bool_only_boolean, clk, rst_n,
    out_valid_r && (out_res_r.cls != ttc_pkg::CLS_BOOLEAN), !out_res_r.bool_value)
  `TTC_ASSERT_IMPLY(a_class_in_range, clk, rst_n,
    out_valid_r, out_res_r.cls <= ttc_pkg::CLS_NAME)
  `TTC_ASSERT_NEXT(a_last_makes_result, clk, rst_n,
    s1_go && s1_last_r, out_valid_r)
  `TTC_ASSERT_NEXT(a_stalled_char_kept, clk, rst_n,
    s1_valid_r && !s1_go, s1_valid_r && $stable(s1_ch_r) && $stable(s1_last_r))
  `TTC_ASSERT_IMPLY(a_no_overrun, clk, rst_n,
    s1_valid_r && s1_last_r && out_valid_r && !out_res.ready, !in_tok.ready)

endmodule

// File: design/ttc_scan.sv
// Per-character flag tracking and final classification of a token.
module ttc_scan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic [ttc_pkg::CH_W-1:0] ch,
  input  logic                     last_char,
  input  logic                     empty_token,
  output ttc_pkg::scan_result_t    result
);

  ttc_pkg::scan_state_t st_r, st_nxt, upd;
  logic is_digit, is_alpha, word_t_ok, word_f_ok, is_true, is_false;
  logic [ttc_pkg::CH_W-1:0] want_t, want_f;

  always_comb begin
    case (st_r.cnt)
      3'd0:    want_t = 8'h74; // t
      3'd1:    want_t = 8'h72; // r
      3'd2:    want_t = 8'h75; // u
      3'd3:    want_t = 8'h65; // e
      default: want_t = 8'h00;
    endcase
    case (st_r.cnt)
      3'd0:    want_f = 8'h66; // f
      3'd1:    want_f = 8'h61; // a
      3'd2:    want_f = 8'h6C; // l
      3'd3:    want_f = 8'h73; // s
      3'd4:    want_f = 8'h65; // e
      default: want_f = 8'h00;
    endcase
  end

  assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_alpha  = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
  assign word_t_ok = (st_r.cnt < 3'd4) && (ch == want_t);
  assign word_f_ok = (st_r.cnt < 3'd5) && (ch == want_f);

  always_comb begin
    upd = st_r;
    if (st_r.cnt == '0) begin
      upd.opened_quote = (ch == ttc_pkg::QUOTE_CH);
      upd.number_ok    = (ch == ttc_pkg::PLUS_CH) || (ch == ttc_pkg::MINUS_CH) || is_digit;
      upd.name_ok      = is_alpha || (ch == ttc_pkg::UNDER_CH);
    end else begin
      if (ch == ttc_pkg::DOT_CH) begin
        // A second dot rules out a number.
        if (st_r.dot_seen) begin
          upd.number_ok = 1'b0;
        end
        upd.dot_seen = 1'b1;
      end else if (!is_digit) begin
        upd.number_ok = 1'b0;
      end
      if (!(is_alpha || is_digit || (ch == ttc_pkg::MINUS_CH) ||
            (ch == ttc_pkg::UNDER_CH))) begin
        upd.name_ok = 1'b0;
      end
    end
    upd.matches_true  = st_r.matches_true && word_t_ok;
    upd.matches_false = st_r.matches_false && word_f_ok;
    upd.latest_quote  = (ch == ttc_pkg::QUOTE_CH);
    if (st_r.cnt < ttc_pkg::COUNT_SAT) begin
      upd.cnt = st_r.cnt + 3'd1;
    end
  end

  assign is_true  = upd.matches_true && (upd.cnt == 3'd4);
  assign is_false = upd.matches_false && (upd.cnt == 3'd5);

  always_comb begin
    result.cls        = ttc_pkg::CLS_INVALID;
    result.bool_value = 1'b0;
    if (empty_token) begin
      result.cls = ttc_pkg::CLS_INVALID;
    end else if ((upd.cnt > 3'd2) && upd.opened_quote && upd.latest_quote) begin
      result.cls = ttc_pkg::CLS_STRING;
    end else if (is_true || is_false) begin
      result.cls        = ttc_pkg::CLS_BOOLEAN;
      result.bool_value = is_true;
    end else if (upd.number_ok) begin
      result.cls = upd.dot_seen ? ttc_pkg::CLS_FLOAT : ttc_pkg::CLS_INTEGER;
    end else if (upd.name_ok) begin
      result.cls = ttc_pkg::CLS_NAME;
    end
  end

  // The token ends with the last character, so the flags start over.
  assign st_nxt = last_char ? ttc_pkg::SCAN_RESET : upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ttc_pkg::SCAN_RESET;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

endmodule
